// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/s5h_pkg.sv =====
package s5h_pkg;

    // Input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // Phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_METHOD = 3'd1;
    localparam logic [2:0] PH_AUTH   = 3'd2;
    localparam logic [2:0] PH_HEAD   = 3'd3;
    localparam logic [2:0] PH_DLEN   = 3'd4;
    localparam logic [2:0] PH_ADDR   = 3'd5;
    localparam logic [2:0] PH_PORT   = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // Status codes
    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_OK          = 4'd1;
    localparam logic [3:0] ST_BAD_MVER    = 4'd2;
    localparam logic [3:0] ST_AUTH_NONE   = 4'd3;
    localparam logic [3:0] ST_NO_METHOD   = 4'd4;
    localparam logic [3:0] ST_UNK_METHOD  = 4'd5;
    localparam logic [3:0] ST_AUTH_FAIL   = 4'd6;
    localparam logic [3:0] ST_CONN_FAIL   = 4'd7;
    localparam logic [3:0] ST_BAD_RVER    = 4'd8;
    localparam logic [3:0] ST_BAD_ATYPE   = 4'd9;
    localparam logic [3:0] ST_TRUNCATED   = 4'd10;

    // Frames to send
    localparam logic [1:0] FR_NONE     = 2'd0;
    localparam logic [1:0] FR_GREETING = 2'd1;
    localparam logic [1:0] FR_AUTH     = 2'd2;
    localparam logic [1:0] FR_CONNECT  = 2'd3;

    // Protocol bytes
    localparam logic [7:0] VER5        = 8'h05;
    localparam logic [7:0] M_NONE      = 8'h00;
    localparam logic [7:0] M_USERPASS  = 8'h02;
    localparam logic [7:0] M_NOACCEPT  = 8'hFF;
    localparam logic [7:0] AT_IPV4     = 8'h01;
    localparam logic [7:0] AT_DOMAIN   = 8'h03;
    localparam logic [7:0] AT_IPV6     = 8'h04;
    localparam logic [7:0] IPV4_LEN    = 8'd4;
    localparam logic [7:0] IPV6_LEN    = 8'd16;

    // Configuration register index
    localparam logic REG_AUTH_OFFERED = 1'b0;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [3:0] status;
        logic [1:0] send_frame;
        logic [7:0] reply_code;
        logic [2:0] phase;
    } t_result;

    typedef struct packed {
        logic       vld;
        t_item      item;
    } t_step_req;

endpackage

// ===== sv/s5h_cfg.sv =====
module s5h_cfg import s5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_auth_offered
);

    logic r_auth_offered;
    logic n_auth_offered;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_AUTH_OFFERED);

    always_comb begin
        n_auth_offered = r_auth_offered;
        if (wr_en) begin
            n_auth_offered = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_offered <= 1'b0;
        end else begin
            r_auth_offered <= n_auth_offered;
        end
    end

    // Only the low bit of the word at register 0 is implemented.
    assign prdata = (paddr[2] == REG_AUTH_OFFERED) ? {31'd0, r_auth_offered} : 32'd0;
    assign o_auth_offered = r_auth_offered;

endmodule

// ===== sv/s5h_core.sv =====
module s5h_core import s5h_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_req i_req,
    input  logic      i_auth_offered,
    output t_result   o_result
);

    logic [2:0] r_phase,    n_phase;
    logic [1:0] r_idx,      n_idx;
    logic [7:0] r_addr_rem, n_addr_rem;
    logic [7:0] r_ver,      n_ver;
    logic [7:0] r_reply,    n_reply;
    logic [3:0] r_status,   n_status;
    logic [1:0] frame;
    logic [7:0] b;
    logic [7:0] addr_dec;

    assign b        = i_req.item.rx_byte;
    assign addr_dec = r_addr_rem - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_addr_rem = r_addr_rem;
        n_ver      = r_ver;
        n_reply    = r_reply;
        n_status   = r_status;
        frame      = FR_NONE;
        if (i_req.vld) begin
            unique case (i_req.item.mode)
                MODE_START: begin
                    n_phase    = PH_METHOD;
                    n_idx      = 2'd0;
                    n_addr_rem = 8'd0;
                    n_ver      = 8'd0;
                    n_reply    = 8'd0;
                    n_status   = ST_BUSY;
                    frame      = FR_GREETING;
                end
                MODE_BYTE: begin
                    unique case (r_phase)
                        PH_METHOD: begin
                            if (r_idx == 2'd0) begin
                                n_ver = b;
                                n_idx = 2'd1;
                            end else begin
                                // Method reply decided on its second byte
                                n_phase = PH_DONE;
                                n_idx   = 2'd0;
                                priority if (r_ver != VER5) begin
                                    n_status = ST_BAD_MVER;
                                end else if (b == M_NONE) begin
                                    n_phase = PH_HEAD;
                                    frame   = FR_CONNECT;
                                end else if (b == M_USERPASS) begin
                                    if (i_auth_offered) begin
                                        n_phase = PH_AUTH;
                                        frame   = FR_AUTH;
                                    end else begin
                                        n_status = ST_AUTH_NONE;
                                    end
                                end else if (b == M_NOACCEPT) begin
                                    n_status = ST_NO_METHOD;
                                end else begin
                                    n_status = ST_UNK_METHOD;
                                end
                            end
                        end
                        PH_AUTH: begin
                            if (r_idx == 2'd0) begin
                                n_idx = 2'd1;
                            end else if (b != 8'd0) begin
                                n_status = ST_AUTH_FAIL;
                                n_phase  = PH_DONE;
                                n_idx    = 2'd0;
                            end else begin
                                n_phase = PH_HEAD;
                                n_idx   = 2'd0;
                                frame   = FR_CONNECT;
                            end
                        end
                        PH_HEAD: begin
                            unique case (r_idx)
                                2'd0: begin
                                    n_ver = b;
                                    n_idx = 2'd1;
                                end
                                2'd1: begin
                                    n_reply = b;
                                    n_idx   = 2'd2;
                                end
                                2'd2: n_idx = 2'd3;
                                default: begin
                                    // Version first, then reply code, then address type
                                    n_idx = 2'd0;
                                    priority if (r_ver != VER5) begin
                                        n_status = ST_BAD_RVER;
                                        n_phase  = PH_DONE;
                                    end else if (r_reply != 8'd0) begin
                                        n_status = ST_CONN_FAIL;
                                        n_phase  = PH_DONE;
                                    end else if (b == AT_IPV4) begin
                                        n_addr_rem = IPV4_LEN;
                                        n_phase    = PH_ADDR;
                                    end else if (b == AT_IPV6) begin
                                        n_addr_rem = IPV6_LEN;
                                        n_phase    = PH_ADDR;
                                    end else if (b == AT_DOMAIN) begin
                                        n_phase = PH_DLEN;
                                    end else begin
                                        n_status = ST_BAD_ATYPE;
                                        n_phase  = PH_DONE;
                                    end
                                end
                            endcase
                        end
                        PH_DLEN: begin
                            n_addr_rem = b;
                            n_idx      = 2'd0;
                            n_phase    = (b == 8'd0) ? PH_PORT : PH_ADDR;
                        end
                        PH_ADDR: begin
                            n_addr_rem = addr_dec;
                            if (addr_dec == 8'd0) begin
                                n_phase = PH_PORT;
                                n_idx   = 2'd0;
                            end
                        end
                        PH_PORT: begin
                            if (r_idx == 2'd0) begin
                                n_idx = 2'd1;
                            end else begin
                                n_status = ST_OK;
                                n_phase  = PH_DONE;
                                n_idx    = 2'd0;
                            end
                        end
                        default: ; // idle or done: hold
                    endcase
                end
                MODE_CLOSE: begin
                    if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                        n_status = ST_TRUNCATED;
                        n_phase  = PH_DONE;
                        n_idx    = 2'd0;
                    end
                end
                default: ; // unused mode: drop
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_idx      <= 2'd0;
            r_addr_rem <= 8'd0;
            r_ver      <= 8'd0;
            r_reply    <= 8'd0;
            r_status   <= ST_BUSY;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_addr_rem <= n_addr_rem;
            r_ver      <= n_ver;
            r_reply    <= n_reply;
            r_status   <= n_status;
        end
    end

    assign o_result.status     = n_status;
    assign o_result.send_frame = frame;
    assign o_result.reply_code = (n_status == ST_CONN_FAIL) ? n_reply : 8'd0;
    assign o_result.phase      = n_phase;

endmodule

// ===== sv/socks5_client_handshake_sequencer.sv =====
// SOCKS5 client handshake sequencer. Every accepted item (start, proxy byte or
// stream closed) yields exactly one result: status, frame to send, connect
// reply code and phase. The block takes one item per clock cycle while the
// output is not stalled. An item is held in the input register; the handshake
// state is updated on the same edge that loads its result into the result register.
// A stalled output holds the pipeline, and the input stalls only when both
// registers are full. auth_offered sits at byte address 0 of the APB port.
module socks5_client_handshake_sequencer import s5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [1:0]  o_send_frame,
    output logic [7:0]  o_reply_code,
    output logic [2:0]  o_phase,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      r_in_vld;
    t_item     r_in;
    logic      r_out_vld;
    t_result   r_out;
    logic      advance;
    logic      auth_offered;
    t_step_req step_req;
    t_result   step_res;

    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;

    s5h_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_auth_offered (auth_offered)
    );

    assign step_req.vld  = r_in_vld && advance;
    assign step_req.item = r_in;

    s5h_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (step_req),
        .i_auth_offered (auth_offered),
        .o_result       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.mode    <= i_mode;
            r_in.rx_byte <= i_rx_byte;
        end
        if (step_req.vld) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out.status;
    assign o_send_frame = r_out.send_frame;
    assign o_reply_code = r_out.reply_code;
    assign o_phase      = r_out.phase;

endmodule

// ===== sv/s5h_checker.sv =====
`include "assert_macros.svh"

module s5h_checker import s5h_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_status,
    input logic [1:0] o_send_frame,
    input logic [7:0] o_reply_code,
    input logic [2:0] o_phase
);

    // A terminal status always comes with the done phase, and back.
    `ASSERT_IMPLY(a_status_done, i_clk, i_rst_n, o_out_valid && (o_status != ST_BUSY), o_phase == PH_DONE, "terminal status outside done phase")
    `ASSERT_IMPLY(a_done_status, i_clk, i_rst_n, o_out_valid && (o_phase == PH_DONE), o_status != ST_BUSY, "done phase with busy status")
    // A frame request only happens while the handshake is still running.
    `ASSERT_IMPLY(a_frame_busy, i_clk, i_rst_n, o_out_valid && (o_send_frame != FR_NONE), (o_status == ST_BUSY) && (o_phase != PH_DONE) && (o_phase != PH_IDLE), "frame request after completion")
    `ASSERT_IMPLY(a_reply_code, i_clk, i_rst_n, o_out_valid && (o_reply_code != 8'd0), o_status == ST_CONN_FAIL, "reply code without connect failure")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_phase) && $stable(o_send_frame), "stalled result changed")

endmodule

bind socks5_client_handshake_sequencer s5h_checker u_s5h_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_send_frame (o_send_frame),
    .o_reply_code (o_reply_code),
    .o_phase      (o_phase)
);
